/* design/snm3d_pkg.sv */
// Shared types and constants for the spherical neighbourhood mean block.
package snm3d_pkg;

  // Volume and sample geometry
  localparam int MAX_DIM     = 16;
  localparam int SAMPLE_BITS = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SIZE_X = 2'd1;
  localparam logic [1:0] REG_SIZE_Y = 2'd2;
  localparam logic [1:0] REG_SIZE_Z = 2'd3;

  // Item kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  localparam int unsigned MEAN_W = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_ROW,
    ST_SQRT,
    ST_RD_HI,
    ST_RD_LO,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  // Control between the top level and the divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* design/snm3d_div.sv */
// Restoring divider, one quotient bit per cycle, saturating to the mean width.
module snm3d_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [NUM_W-1:0]                  num,
  input  logic [DEN_W-1:0]                  den,
  output snm3d_pkg::div_ctl_t               ctl,
  output logic [snm3d_pkg::MEAN_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  // On start load the operands, else while busy shift one numerator bit into the remainder and try a subtract
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quo = (q_r[NUM_W-1:snm3d_pkg::MEAN_W] != '0) ? '1 : q_r[snm3d_pkg::MEAN_W-1:0];

  // Done comes only out of a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !start |=> !busy_r) else $error("divider started by itself");

endmodule

/* design/spherical_neighbourhood_mean_3d.sv */
// Top level: row prefix-sum store with load and spherical mean query sequencer.
//
//  channel | direction | payload
//  in_     | slave     | tdata {sample,pos_z,pos_y,pos_x}, tuser op
//  out_    | master    | tdata mean_q8, tuser status
//  cfg_    | slave     | cfg_index register, cfg_data value
//
// A load is accepted, reads the previous entry and then writes the sum. A query
// visits each candidate (y,z) row: a row outside the ball goes from ST_ROW to
// ST_ACC, a row inside it runs ST_ROW, up to 16 square-root steps, ST_RD_HI,
// ST_RD_LO and ST_ACC; ST_DIV then launches the 38-bit divider. At radius 15 there
// are up to 16*16 rows. The serial square root and the single store port set the query time.
// Reset is synchronous; nothing clears the store. One item is in work at a
// time, and a finished result waits in the output register until taken.
module spherical_neighbourhood_mean_3d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pos_x[3:0], pos_y[7:4], pos_z[11:8], sample[27:12]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // mean_q8[23:0]
  output logic        out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int DW     = $clog2(snm3d_pkg::MAX_DIM);
  localparam int AW     = 3 * DW;
  localparam int DEPTH  = snm3d_pkg::MAX_DIM * snm3d_pkg::MAX_DIM * snm3d_pkg::MAX_DIM;
  localparam int ENT_W  = snm3d_pkg::SAMPLE_BITS + DW;
  localparam int SUM_W  = ENT_W + 2 * DW + 2;
  localparam int CNT_W  = 3 * DW + 1;
  localparam int NUM_W  = SUM_W + 8;
  localparam int D_W    = 10;

  // Configuration
  logic [3:0] radius_r;
  logic [4:0] size_x_r, size_y_r, size_z_r;
  logic [5:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 4'd1;
      size_x_r <= 5'd16;
      size_y_r <= 5'd16;
      size_z_r <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        snm3d_pkg::REG_RADIUS: radius_r <= cfg_data[3:0];
        snm3d_pkg::REG_SIZE_X: size_x_r <= cfg_data;
        snm3d_pkg::REG_SIZE_Y: size_y_r <= cfg_data;
        snm3d_pkg::REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  function automatic logic [5:0] eff(input logic [4:0] v);
    if (v == 5'd0) return 6'd1;
    if (32'(v) > snm3d_pkg::MAX_DIM) return 6'(snm3d_pkg::MAX_DIM);
    return {1'b0, v};
  endfunction
  assign sx = eff(size_x_r);
  assign sy = eff(size_y_r);
  assign sz = eff(size_z_r);

  // Store
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Item registers
  snm3d_pkg::state_t st_r, st_nxt;
  logic [DW-1:0] px_r, py_r, pz_r;
  logic [snm3d_pkg::SAMPLE_BITS-1:0] smp_r;
  logic signed [6:0] j_r, j_nxt, k_r, k_nxt;   // row cursor
  logic signed [6:0] y0, y1, z1;
  logic [D_W-1:0] d_r, d_nxt;
  logic [4:0] h_r, h_nxt;                      // sqrt candidate
  logic [DW-1:0] i0_r, i0_nxt, i1_r, i1_nxt;
  logic [ENT_W-1:0] hi_r, hi_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] num_r, num_nxt;
  logic [23:0] mean_r, mean_nxt;
  logic status_r, status_nxt;
  logic out_v_r, out_v_nxt;
  logic div_start;
  snm3d_pkg::div_ctl_t div_ctl;
  logic [23:0] div_q;

  logic in_acc;
  logic inside_in;
  logic signed [7:0] dy, dz;
  logic signed [10:0] rr, dy2, dz2;
  logic signed [10:0] drow;
  logic signed [6:0] xl, xh;
  logic [5:0] hp1;

  assign in_acc = in_tvalid && in_tready;
  assign inside_in = ({2'b0, in_tdata[3:0]} < sx) && ({2'b0, in_tdata[7:4]} < sy)
                     && ({2'b0, in_tdata[11:8]} < sz);
  assign in_tready = (st_r == snm3d_pkg::ST_IDLE) && !out_v_r;

  assign y0 = ($signed({3'b0, py_r}) - $signed({3'b0, radius_r}) < 0) ? 7'sd0
              : 7'($signed({3'b0, py_r}) - $signed({3'b0, radius_r}));
  assign y1 = ($signed({3'b0, py_r}) + $signed({3'b0, radius_r}) > $signed({1'b0, sy}) - 1)
              ? 7'($signed({1'b0, sy}) - 1) : 7'($signed({3'b0, py_r}) + $signed({3'b0, radius_r}));
  assign z1 = ($signed({3'b0, pz_r}) + $signed({3'b0, radius_r}) > $signed({1'b0, sz}) - 1)
              ? 7'($signed({1'b0, sz}) - 1) : 7'($signed({3'b0, pz_r}) + $signed({3'b0, radius_r}));
  assign dy = 8'(j_r) - 8'(signed'({4'b0, py_r}));
  assign dz = 8'(k_r) - 8'(signed'({4'b0, pz_r}));
  // Squared distances at full 11-bit width
  assign rr   = $signed({7'b0, radius_r}) * $signed({7'b0, radius_r});
  assign dy2  = 11'(dy) * 11'(dy);
  assign dz2  = 11'(dz) * 11'(dz);
  assign drow = rr - dy2 - dz2;
  assign hp1 = {1'b0, h_r} + 6'd1;
  assign xl = 7'(signed'({3'b0, px_r})) - 7'(signed'({2'b0, h_r}));
  assign xh = 7'(signed'({3'b0, px_r})) + 7'(signed'({2'b0, h_r}));

  // Sequencer
  always_comb begin
    st_nxt     = st_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    d_nxt      = d_r;
    h_nxt      = h_r;
    i0_nxt     = i0_r;
    i1_nxt     = i1_r;
    hi_nxt     = hi_r;
    sum_nxt    = sum_r;
    num_nxt    = num_r;
    mean_nxt   = mean_r;
    status_nxt = status_r;
    out_v_nxt  = out_v_r && !out_tready;
    rd_addr    = {pz_r, py_r, px_r - DW'(1)};
    wr_addr    = {pz_r, py_r, px_r};
    wr_en      = 1'b0;
    wr_data    = ENT_W'(smp_r) + ((px_r == '0) ? '0 : rd_data_r);
    div_start  = 1'b0;
    case (st_r)
      snm3d_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == snm3d_pkg::OP_LOAD) begin
            st_nxt = inside_in ? snm3d_pkg::ST_LD_RD : snm3d_pkg::ST_IDLE;
          end else if (!inside_in) begin
            mean_nxt   = '0;
            status_nxt = snm3d_pkg::STATUS_OUTSIDE;
            out_v_nxt  = 1'b1;
          end else begin
            st_nxt = snm3d_pkg::ST_ROW;
          end
        end
      end
      snm3d_pkg::ST_LD_RD: st_nxt = snm3d_pkg::ST_LD_WR;
      snm3d_pkg::ST_LD_WR: begin
        wr_en  = 1'b1;
        st_nxt = snm3d_pkg::ST_IDLE;
      end
      snm3d_pkg::ST_ROW: begin
        // Skip rows outside the ball, else start the square root
        h_nxt = '0;
        d_nxt = drow[D_W-1:0];
        st_nxt = drow < 0 ? snm3d_pkg::ST_ACC : snm3d_pkg::ST_SQRT;
        if (drow < 0) hi_nxt = '0;
      end
      snm3d_pkg::ST_SQRT: begin
        if (({5'b0, hp1} * {5'b0, hp1}) <= {1'b0, d_r}) begin
          h_nxt = hp1[4:0];
        end else begin
          i0_nxt = xl < 0 ? '0 : DW'(xl);
          i1_nxt = (xh > 7'($signed({1'b0, sx}) - 1)) ? DW'(sx - 6'd1) : DW'(xh);
          st_nxt = snm3d_pkg::ST_RD_HI;
        end
      end
      snm3d_pkg::ST_RD_HI: begin
        rd_addr = {DW'(k_r), DW'(j_r), i1_r};
        st_nxt  = snm3d_pkg::ST_RD_LO;
      end
      snm3d_pkg::ST_RD_LO: begin
        rd_addr = {DW'(k_r), DW'(j_r), i0_r - DW'(1)};
        hi_nxt  = rd_data_r;
        st_nxt  = snm3d_pkg::ST_ACC;
      end
      snm3d_pkg::ST_ACC: begin
        if (!(drow < 0)) begin
          sum_nxt = sum_r + SUM_W'(hi_r)
                    - ((i0_r == '0) ? '0 : SUM_W'(rd_data_r));
          num_nxt = num_r + CNT_W'(i1_r) - CNT_W'(i0_r) + CNT_W'(1);
        end
        // Advance to the next row, or to the division after the last one
        if (j_r == y1) begin
          j_nxt = y0;
          k_nxt = k_r + 7'sd1;
          st_nxt = (k_r == z1) ? snm3d_pkg::ST_DIV : snm3d_pkg::ST_ROW;
        end else begin
          j_nxt  = j_r + 7'sd1;
          st_nxt = snm3d_pkg::ST_ROW;
        end
      end
      snm3d_pkg::ST_DIV: begin
        if (num_r == '0 || sum_r <= 0) begin
          mean_nxt   = '0;
          status_nxt = snm3d_pkg::STATUS_OK;
          out_v_nxt  = 1'b1;
          st_nxt     = snm3d_pkg::ST_IDLE;
        end else begin
          div_start = 1'b1;
          st_nxt    = snm3d_pkg::ST_OUT;
        end
      end
      snm3d_pkg::ST_OUT: begin
        if (div_ctl.done) begin
          mean_nxt   = div_q;
          status_nxt = snm3d_pkg::STATUS_OK;
          out_v_nxt  = 1'b1;
          st_nxt     = snm3d_pkg::ST_IDLE;
        end
      end
      default: st_nxt = snm3d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= snm3d_pkg::ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      out_v_r <= out_v_nxt;
    end
    if (in_acc) begin
      px_r  <= in_tdata[3:0];
      py_r  <= in_tdata[7:4];
      pz_r  <= in_tdata[11:8];
      smp_r <= in_tdata[12 +: snm3d_pkg::SAMPLE_BITS];
    end
    // Start of a query: first row, clear accumulators
    if (st_r == snm3d_pkg::ST_IDLE) begin
      sum_r <= '0;
      num_r <= '0;
      j_r   <= (in_tdata[7:4] < radius_r) ? 7'sd0
               : 7'(signed'({3'b0, in_tdata[7:4]}) - signed'({3'b0, radius_r}));
      k_r   <= (in_tdata[11:8] < radius_r) ? 7'sd0
               : 7'(signed'({3'b0, in_tdata[11:8]}) - signed'({3'b0, radius_r}));
    end else begin
      sum_r <= sum_nxt;
      num_r <= num_nxt;
      j_r   <= j_nxt;
      k_r   <= k_nxt;
    end
    d_r      <= d_nxt;
    h_r      <= h_nxt;
    i0_r     <= i0_nxt;
    i1_r     <= i1_nxt;
    hi_r     <= hi_nxt;
    mean_r   <= mean_nxt;
    status_r <= status_nxt;
  end

  snm3d_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({SUM_W'(unsigned'(sum_r)), 8'd0}),
    .den   (num_r),
    .ctl   (div_ctl),
    .quo   (div_q)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = mean_r;
  assign out_tuser  = status_r;

  // Input is closed while a result waits
  a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !in_tready) else $error("input open with pending result");
  a_wr_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(st_r) == snm3d_pkg::ST_LD_RD) else $error("stray store write");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(mean_r)) else $error("result dropped");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_ctl.busy) else $error("division launched while busy");

endmodule

/* verif/tb_spherical_neighbourhood_mean_3d.sv */
// Self-checking testbench for the spherical neighbourhood mean block.
module tb_spherical_neighbourhood_mean_3d;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM        = 16;
  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE     = 40;
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 105;

  typedef struct {
    logic [23:0] mean;
    logic        status;
  } mean_result_t;

  typedef struct {
    logic        op;
    int          x, y, z;
    int          smp;
    bit          typed;
    int          mean;
    logic        status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  // Mirror of the prefix store and the registers
  logic [19:0] prefix_mem [DIM*DIM*DIM];
  bit          gen_written [DIM*DIM*DIM];
  int          mir_radius, m_sx, m_sy, m_sz;

  mean_result_t pending_means[$];
  int          err_count = 0;
  int          sent_count = 0;
  int          idle_mode = 0;
  int          stall_cycles = 0;

  spherical_neighbourhood_mean_3d u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_size(int v);
    if (v < 1) return 1;
    if (v > DIM) return DIM;
    return v;
  endfunction

  function automatic int addr_of(int x, int y, int z);
    return (z * DIM + y) * DIM + x;
  endfunction

  function automatic int root_floor(int d);
    int s;
    s = 0;
    while ((s + 1) * (s + 1) <= d) s++;
    return s;
  endfunction

  function automatic bit is_inside(int x, int y, int z);
    return x < m_sx && y < m_sy && z < m_sz;
  endfunction

  // Check that every prefix read a query would make hits a loaded entry
  function automatic bit query_reads_loaded(int x, int y, int z);
    int d, h, i0, i1;
    if (!is_inside(x, y, z)) return 1'b1;
    for (int k = 0; k < m_sz; k++) begin
      for (int j = 0; j < m_sy; j++) begin
        d = mir_radius * mir_radius - (y - j) * (y - j) - (z - k) * (z - k);
        if (d < 0) continue;
        h = root_floor(d);
        i0 = (x - h < 0) ? 0 : x - h;
        i1 = (x + h > m_sx - 1) ? m_sx - 1 : x + h;
        if (!gen_written[addr_of(i1, j, k)]) return 1'b0;
        if (i0 > 0 && !gen_written[addr_of(i0 - 1, j, k)]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Apply one accepted item to the mirror; returns 1 when a result follows
  function automatic bit mean_of_item(input logic op, input int x, y, z, smp,
                                      output mean_result_t res);
    longint sum, num, q;
    int d, h, i0, i1, a;
    sum = 0;
    num = 0;
    res.mean = '0;
    res.status = snm3d_pkg::STATUS_OK;
    if (op == snm3d_pkg::OP_LOAD) begin
      if (is_inside(x, y, z)) begin
        a = addr_of(x, y, z);
        prefix_mem[a] = 20'(smp & 16'hFFFF) + ((x == 0) ? 20'd0 : prefix_mem[a - 1]);
      end
      return 1'b0;
    end
    if (!is_inside(x, y, z)) begin
      res.status = snm3d_pkg::STATUS_OUTSIDE;
      return 1'b1;
    end
    for (int k = 0; k < m_sz; k++) begin
      for (int j = 0; j < m_sy; j++) begin
        d = mir_radius * mir_radius - (y - j) * (y - j) - (z - k) * (z - k);
        if (d < 0) continue;
        h = root_floor(d);
        i0 = (x - h < 0) ? 0 : x - h;
        i1 = (x + h > m_sx - 1) ? m_sx - 1 : x + h;
        sum += longint'(prefix_mem[addr_of(i1, j, k)]);
        if (i0 > 0) sum -= longint'(prefix_mem[addr_of(i0 - 1, j, k)]);
        num += i1 - i0 + 1;
      end
    end
    if (num > 0 && sum > 0) begin
      q = (sum * 256) / num;
      res.mean = (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Send one item; when typed, the table value replaces the prediction
  task automatic send_item(input logic op, input int x, y, z, smp,
                           input bit typed = 0, input int tmean = 0,
                           input logic tstat = snm3d_pkg::STATUS_OK);
    mean_result_t res;
    int idle_pct;
    idle_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 80 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {4'b0, 16'(smp), 4'(z), 4'(y), 4'(x)};
    do @(posedge clk); while (!in_tready);
    if (mean_of_item(op, x, y, z, smp, res)) begin
      if (typed) begin
        res.mean = 24'(tmean);
        res.status = tstat;
      end
      pending_means.push_back(res);
    end
    if (op == snm3d_pkg::OP_LOAD && is_inside(x, y, z)) gen_written[addr_of(x, y, z)] = 1'b1;
    sent_count++;
    if (sent_count == 290) idle_mode = 1;
    if (sent_count == 580) idle_mode = 2;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = 5'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      snm3d_pkg::REG_RADIUS: mir_radius = val & 15;
      snm3d_pkg::REG_SIZE_X: m_sx = clamp_size(val & 31);
      snm3d_pkg::REG_SIZE_Y: m_sy = clamp_size(val & 31);
      default:               m_sz = clamp_size(val & 31);
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until all results are back and a trailing load has finished
  task automatic drain();
    while (pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_row(input int y, z);
    for (int x = 0; x < m_sx; x++)
      send_item(snm3d_pkg::OP_LOAD, x, y, z, $urandom_range(65535));
  endtask

  // Receiver side: stall at random according to the current mode
  always @(negedge clk) begin
    out_tready <= $urandom_range(99) >= ((idle_mode == 0) ? 80 : (idle_mode == 1) ? 22 : 0);
  end

  // Check results and watch for a stuck block
  always @(posedge clk) begin
    mean_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_means.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_res = pending_means.pop_front();
        if (out_tdata !== exp_res.mean)
          report_mismatch($sformatf("mean_q8 %h, expected %h", out_tdata, exp_res.mean));
        if (out_tuser !== exp_res.status)
          report_mismatch($sformatf("status %b, expected %b", out_tuser, exp_res.status));
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Directed rows: radius 0 over the full volume
  stim_row_t directed_rows [12] = '{
    '{snm3d_pkg::OP_LOAD,  0,  0,  0, 65535, 0, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_LOAD,  1,  0,  0, 65535, 0, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_QUERY, 1,  0,  0, 0,     1, 24'hFFFF00, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_QUERY, 0,  0,  0, 0,     1, 24'hFFFF00, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_LOAD,  0, 15, 15, 0,     0, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_QUERY, 0, 15, 15, 65535, 1, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_LOAD,  0,  0,  0, 1,     0, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_QUERY, 1,  0,  0, 0,     1, 24'hFFFFFF, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_LOAD,  1,  0,  0, 0,     0, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_LOAD,  0,  0,  0, 5,     0, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_QUERY, 1,  0,  0, 0,     1, 0, snm3d_pkg::STATUS_OK},
    '{snm3d_pkg::OP_LOAD,  2,  0,  0, 300,   0, 0, snm3d_pkg::STATUS_OK}
  };

  // Register settings per random phase: radius, size_x, size_y, size_z
  int phase_cfg [N_PHASES][4] = '{
    '{1, 16, 16, 16}, '{15, 16, 2, 2}, '{0, 1, 1, 1}, '{3, 0, 4, 5},
    '{2, 31, 3, 3},   '{5, 4, 4, 4},   '{7, 8, 2, 3}, '{1, 2, 16, 1}
  };

  initial begin
    int budget, x, y, z, pick, tries;
    bit found;
    for (int i = 0; i < DIM*DIM*DIM; i++) begin
      prefix_mem[i] = '0;
      gen_written[i] = 1'b0;
    end
    mir_radius = 1;
    m_sx = 16;
    m_sy = 16;
    m_sz = 16;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(snm3d_pkg::REG_RADIUS, 0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].z, directed_rows[i].smp, directed_rows[i].typed,
                directed_rows[i].mean, directed_rows[i].status);
    send_item(snm3d_pkg::OP_QUERY, 2, 0, 0, 0);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_reg(snm3d_pkg::REG_RADIUS, phase_cfg[p][0]);
      write_reg(snm3d_pkg::REG_SIZE_X, phase_cfg[p][1]);
      write_reg(snm3d_pkg::REG_SIZE_Y, phase_cfg[p][2]);
      write_reg(snm3d_pkg::REG_SIZE_Z, phase_cfg[p][3]);
      budget = sent_count + PHASE_ITEMS;
      while (sent_count < budget) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          // fill one whole row in rising x order
          load_row($urandom_range(m_sy - 1), $urandom_range(m_sz - 1));
        end else if (pick < 80) begin
          // query a voxel whose reads all hit loaded entries, else fill a row
          found = 1'b0;
          for (tries = 0; tries < 20 && !found; tries++) begin
            x = $urandom_range(m_sx - 1);
            y = $urandom_range(m_sy - 1);
            z = $urandom_range(m_sz - 1);
            found = query_reads_loaded(x, y, z);
          end
          if (found) send_item(snm3d_pkg::OP_QUERY, x, y, z, $urandom_range(65535));
          else load_row($urandom_range(m_sy - 1), $urandom_range(m_sz - 1));
        end else if (pick < 90) begin
          // out of range load or query; only possible in a reduced volume
          x = $urandom_range(15);
          y = $urandom_range(15);
          z = $urandom_range(15);
          if (!is_inside(x, y, z))
            send_item(($urandom_range(1) == 1) ? snm3d_pkg::OP_QUERY : snm3d_pkg::OP_LOAD,
                      x, y, z, $urandom_range(65535));
        end else begin
          // single rewrite, possibly out of order, with an extreme sample now and then
          x = $urandom_range(m_sx - 1);
          y = $urandom_range(m_sy - 1);
          z = $urandom_range(m_sz - 1);
          if (x == 0 || gen_written[addr_of(x - 1, y, z)])
            send_item(snm3d_pkg::OP_LOAD, x, y, z,
                      ($urandom_range(1) == 1) ? 65535 : $urandom_range(65535));
        end
      end
    end

    drain();
    if (err_count == 0 && pending_means.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
